// ===== hdl/blms_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and floating-point helpers for the broken-line max statistic
// no dependencies; imported by every other file of the block

package blms_pkg;

    localparam logic [63:0] QNAN_POS = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] QNAN_DEF = 64'hFFF8_0000_0000_0000;
    localparam int          IN_W     = 512;
    localparam int          OUT_W    = 72;

    typedef enum logic [1:0] {FOP_ADD, FOP_SUB, FOP_MUL, FOP_DIV} t_fop;

    typedef enum logic [4:0] {
        R_XL, R_XH, R_PR, R_SXX, R_SX1, R_S11, R_CDIV, R_EDIV,
        R_PS, R_MAX, R_VX, R_VA, R_VB, R_T0, R_T1, R_TH, R_N, R_TM
    } t_reg;

    typedef enum logic [1:0] {SQ_NEXT, SQ_BRANCH, SQ_TERM, SQ_FIRST} t_seq;

    typedef struct packed {
        t_fop op;
        t_reg a;
        t_reg b;
        t_reg d;
        t_seq seq;
    } t_uop;

    typedef struct packed {
        logic load;
        logic start;
        t_uop uop;
        logic wr;
        logic upd_max;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic fdone;
        logic interior;
        logic first;
    } t_sts;

    typedef enum logic [2:0] {C_IDLE, C_START, C_ISSUE, C_WAIT, C_BR, C_MAX, C_OUT} t_cstate;

    typedef enum logic [3:0] {
        F_IDLE, F_ADD, F_PRE, F_MUL, F_DIV, F_NORM, F_DENORM, F_ROUND, F_DONE
    } t_fstate;

    localparam logic [4:0] STEP_FIRST = 5'd0;
    localparam logic [4:0] STEP_LATER = 5'd4;
    localparam logic [4:0] STEP_INT   = 5'd15;
    localparam logic [4:0] STEP_EXT   = 5'd19;

    function automatic t_uop mk(input t_fop op, input t_reg a, input t_reg b,
                                input t_reg d, input t_seq seq);
        t_uop u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.d   = d;
        u.seq = seq;
        return u;
    endfunction

    // operation sequence; first item at STEP_FIRST, later items at STEP_LATER
    function automatic t_uop blms_prog(input logic [4:0] step);
        t_uop u;
        case (step)
            5'd0:  u = mk(FOP_SUB, R_XH,  R_XL,   R_T0,  SQ_NEXT);
            5'd1:  u = mk(FOP_MUL, R_T0,  R_PR,   R_PS,  SQ_NEXT);
            5'd2:  u = mk(FOP_MUL, R_PS,  R_PS,   R_N,   SQ_NEXT);
            5'd3:  u = mk(FOP_DIV, R_N,   R_EDIV, R_MAX, SQ_FIRST);
            5'd4:  u = mk(FOP_MUL, R_PR,  R_XH,   R_T0,  SQ_NEXT);
            5'd5:  u = mk(FOP_ADD, R_PS,  R_T0,   R_VX,  SQ_NEXT);
            5'd6:  u = mk(FOP_MUL, R_PR,  R_XL,   R_T1,  SQ_NEXT);
            5'd7:  u = mk(FOP_SUB, R_VX,  R_T1,   R_PS,  SQ_NEXT);
            5'd8:  u = mk(FOP_MUL, R_VX,  R_SX1,  R_T0,  SQ_NEXT);
            5'd9:  u = mk(FOP_MUL, R_PR,  R_SXX,  R_T1,  SQ_NEXT);
            5'd10: u = mk(FOP_SUB, R_T0,  R_T1,   R_VA,  SQ_NEXT);
            5'd11: u = mk(FOP_MUL, R_VX,  R_S11,  R_T0,  SQ_NEXT);
            5'd12: u = mk(FOP_MUL, R_PR,  R_SX1,  R_T1,  SQ_NEXT);
            5'd13: u = mk(FOP_SUB, R_T0,  R_T1,   R_VB,  SQ_NEXT);
            5'd14: u = mk(FOP_DIV, R_VA,  R_VB,   R_TH,  SQ_BRANCH);
            5'd15: u = mk(FOP_MUL, R_VX,  R_VB,   R_T0,  SQ_NEXT);
            5'd16: u = mk(FOP_MUL, R_PR,  R_VA,   R_T1,  SQ_NEXT);
            5'd17: u = mk(FOP_SUB, R_T0,  R_T1,   R_N,   SQ_NEXT);
            5'd18: u = mk(FOP_DIV, R_N,   R_CDIV, R_TM,  SQ_TERM);
            5'd19: u = mk(FOP_MUL, R_PS,  R_PS,   R_N,   SQ_NEXT);
            5'd20: u = mk(FOP_DIV, R_N,   R_EDIV, R_TM,  SQ_TERM);
            default: u = mk(FOP_ADD, R_T0, R_T0, R_T0, SQ_TERM);
        endcase
        return u;
    endfunction

    function automatic logic fp_isnan(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

    // ieee a > b, false when either is nan
    function automatic logic fp_gt(input logic [63:0] a, input logic [63:0] b);
        logic r;
        r = 1'b0;
        if (fp_isnan(a) || fp_isnan(b)) begin
            r = 1'b0;
        end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
            r = 1'b0;
        end else if (a[63] != b[63]) begin
            r = !a[63];
        end else if (!a[63]) begin
            r = a[62:0] > b[62:0];
        end else begin
            r = a[62:0] < b[62:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/blms_fpu.sv =====
`timescale 1ns / 1ps
// multi-cycle double precision add, subtract, multiply and divide, round to nearest even
// depends on blms_pkg

module blms_fpu import blms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_fop        i_op,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_res
);

    t_fstate            r_fst, n_fst;
    t_fop               r_op, n_op;
    logic               r_sa, n_sa, r_sb, n_sb, r_s, n_s, r_stk, n_stk;
    logic signed [13:0] r_ea, n_ea, r_eb, n_eb, r_e, n_e;
    logic [52:0]        r_ma, n_ma, r_mb, n_mb;
    logic [63:0]        r_m, n_m, r_res, n_res;
    logic [105:0]       r_acc, n_acc;
    logic [5:0]         r_cnt, n_cnt;
    logic [53:0]        r_rem, n_rem;

    // operand unpack
    logic        b_nan_raw, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_s, b_s;
    logic [63:0] b_eff, qa, qb;
    logic [52:0] a_m, b_m;
    logic signed [13:0] a_e, b_e;
    logic        spec_hit;
    logic [63:0] spec_val;

    assign b_nan_raw = fp_isnan(i_b);
    assign b_eff  = (i_op == FOP_SUB && !b_nan_raw) ? {~i_b[63], i_b[62:0]} : i_b;
    assign a_nan  = fp_isnan(i_a);
    assign b_nan  = b_nan_raw;
    assign a_inf  = (i_a[62:52] == 11'h7FF) && (i_a[51:0] == 52'd0);
    assign b_inf  = (i_b[62:52] == 11'h7FF) && (i_b[51:0] == 52'd0);
    assign a_zero = (i_a[62:0] == 63'd0);
    assign b_zero = (i_b[62:0] == 63'd0);
    assign a_s    = i_a[63];
    assign b_s    = b_eff[63];
    assign a_m    = {i_a[62:52] != 11'd0, i_a[51:0]};
    assign b_m    = {i_b[62:52] != 11'd0, i_b[51:0]};
    assign a_e    = (i_a[62:52] == 11'd0) ? 14'sd1 : signed'({3'b000, i_a[62:52]});
    assign b_e    = (i_b[62:52] == 11'd0) ? 14'sd1 : signed'({3'b000, i_b[62:52]});
    assign qa     = {i_a[63:52], 1'b1, i_a[50:0]};
    assign qb     = {i_b[63:52], 1'b1, i_b[50:0]};

    always_comb begin
        spec_hit = 1'b1;
        spec_val = 64'd0;
        case (i_op)
            FOP_ADD, FOP_SUB: begin
                if (a_nan)                  spec_val = qa;
                else if (b_nan)             spec_val = qb;
                else if (a_inf && b_inf)    spec_val = (a_s == b_s) ? i_a : QNAN_DEF;
                else if (a_inf)             spec_val = i_a;
                else if (b_inf)             spec_val = b_eff;
                else if (a_zero && b_zero)  spec_val = {a_s & b_s, 63'd0};
                else if (a_zero)            spec_val = b_eff;
                else if (b_zero)            spec_val = i_a;
                else                        spec_hit = 1'b0;
            end
            FOP_MUL: begin
                if (a_nan)                                    spec_val = qa;
                else if (b_nan)                               spec_val = qb;
                else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = QNAN_DEF;
                else if (a_inf || b_inf)    spec_val = {a_s ^ b_s, 11'h7FF, 52'd0};
                else if (a_zero || b_zero)  spec_val = {a_s ^ b_s, 63'd0};
                else                        spec_hit = 1'b0;
            end
            FOP_DIV: begin
                if (b_zero)                 spec_val = (a_nan || a_zero) ? QNAN_POS :
                                                       {a_s ^ b_s, 11'h7FF, 52'd0};
                else if (a_nan)             spec_val = qa;
                else if (b_nan)             spec_val = qb;
                else if (a_inf && b_inf)    spec_val = QNAN_DEF;
                else if (a_inf)             spec_val = {a_s ^ b_s, 11'h7FF, 52'd0};
                else if (b_inf || a_zero)   spec_val = {a_s ^ b_s, 63'd0};
                else                        spec_hit = 1'b0;
            end
            default: spec_hit = 1'b0;
        endcase
    end

    // alignment add path
    logic               a_big;
    logic [52:0]        big_m, sml_m;
    logic signed [13:0] big_e, sml_e, e_diff;
    logic [63:0]        w_big, w_sml, w_al, w_mask, w_sum;

    always_comb begin
        a_big  = (r_ea > r_eb) || ((r_ea == r_eb) && (r_ma >= r_mb));
        big_m  = a_big ? r_ma : r_mb;
        sml_m  = a_big ? r_mb : r_ma;
        big_e  = a_big ? r_ea : r_eb;
        sml_e  = a_big ? r_eb : r_ea;
        e_diff = big_e - sml_e;
        w_big  = {1'b0, big_m, 10'd0};
        w_sml  = {1'b0, sml_m, 10'd0};
        w_mask = (64'd1 << e_diff[5:0]) - 64'd1;
        if (e_diff > 14'sd63) begin
            w_al = {63'd0, |w_sml};
        end else begin
            w_al    = w_sml >> e_diff[5:0];
            w_al[0] = w_al[0] | (|(w_sml & w_mask));
        end
        w_sum = (r_sa == r_sb) ? (w_big + w_al) : (w_big - w_al);
    end

    // partial products, 27 by 27 bits per cycle
    logic [26:0]  pp_x, pp_y;
    logic [53:0]  pp;
    logic [6:0]   pp_sh;
    assign pp_x  = r_cnt[1] ? {1'b0, r_ma[52:27]} : r_ma[26:0];
    assign pp_y  = r_cnt[0] ? {1'b0, r_mb[52:27]} : r_mb[26:0];
    assign pp    = pp_x * pp_y;
    assign pp_sh = (r_cnt[1] ? 7'd27 : 7'd0) + (r_cnt[0] ? 7'd27 : 7'd0);

    // restoring division step
    logic        dv_ge;
    logic [53:0] dv_diff, dv_rem;
    assign dv_ge   = r_rem >= {1'b0, r_mb};
    assign dv_diff = dv_ge ? (r_rem - {1'b0, r_mb}) : r_rem;
    assign dv_rem  = {dv_diff[52:0], 1'b0};

    // rounding
    logic               rd_inc;
    logic [53:0]        rd_m;
    logic signed [13:0] rd_e;
    logic [10:0]        rd_exp;
    assign rd_inc = r_m[10] & ((|r_m[9:0]) | r_stk | r_m[11]);
    assign rd_m   = {1'b0, r_m[63:11]} + {53'd0, rd_inc};
    assign rd_e   = rd_m[53] ? (r_e + 14'sd1) : r_e;
    assign rd_exp = (rd_m[53] || rd_m[52]) ? rd_e[10:0] : 11'd0;

    always_comb begin
        n_fst = r_fst;
        n_op  = r_op;
        n_sa  = r_sa;
        n_sb  = r_sb;
        n_s   = r_s;
        n_ea  = r_ea;
        n_eb  = r_eb;
        n_ma  = r_ma;
        n_mb  = r_mb;
        n_m   = r_m;
        n_e   = r_e;
        n_stk = r_stk;
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_res = r_res;
        case (r_fst)
            F_IDLE: begin
                if (i_start) begin
                    n_op = i_op;
                    n_sa = a_s;
                    n_sb = b_s;
                    n_ea = a_e;
                    n_eb = b_e;
                    n_ma = a_m;
                    n_mb = b_m;
                    n_stk = 1'b0;
                    if (spec_hit) begin
                        n_res = spec_val;
                        n_fst = F_DONE;
                    end else if (i_op == FOP_ADD || i_op == FOP_SUB) begin
                        n_fst = F_ADD;
                    end else begin
                        n_fst = F_PRE;
                    end
                end
            end
            F_ADD: begin
                n_m   = w_sum;
                n_e   = big_e + 14'sd1;
                n_s   = a_big ? r_sa : r_sb;
                n_stk = 1'b0;
                n_fst = F_NORM;
            end
            F_PRE: begin
                // bring subnormal mantissas up to a leading one
                if (!r_ma[52]) begin
                    n_ma = {r_ma[51:0], 1'b0};
                    n_ea = r_ea - 14'sd1;
                end else if (!r_mb[52]) begin
                    n_mb = {r_mb[51:0], 1'b0};
                    n_eb = r_eb - 14'sd1;
                end else begin
                    n_cnt = 6'd0;
                    n_acc = 106'd0;
                    n_rem = {1'b0, r_ma};
                    n_fst = (r_op == FOP_MUL) ? F_MUL : F_DIV;
                end
            end
            F_MUL: begin
                if (r_cnt == 6'd4) begin
                    n_m   = r_acc[105:42];
                    n_stk = |r_acc[41:0];
                    n_e   = r_ea + r_eb - 14'sd1022;
                    n_s   = r_sa ^ r_sb;
                    n_fst = F_NORM;
                end else begin
                    n_acc = r_acc + ({52'd0, pp} << pp_sh);
                    n_cnt = r_cnt + 6'd1;
                end
            end
            F_DIV: begin
                n_rem = dv_rem;
                n_m   = {r_m[62:0], dv_ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_stk = dv_rem != 54'd0;
                    n_e   = r_ea - r_eb + 14'sd1023;
                    n_s   = r_sa ^ r_sb;
                    n_fst = F_NORM;
                end
            end
            F_NORM: begin
                if (r_m == 64'd0 && !r_stk) begin
                    // exact cancellation gives +0
                    n_res = 64'd0;
                    n_fst = F_DONE;
                end else if (!r_m[63] && r_e > 14'sd1) begin
                    n_m = {r_m[62:0], 1'b0};
                    n_e = r_e - 14'sd1;
                end else begin
                    n_fst = F_DENORM;
                end
            end
            F_DENORM: begin
                if (r_e < 14'sd1) begin
                    if (r_e < -14'sd62) begin
                        n_stk = r_stk | (|r_m);
                        n_m   = 64'd0;
                        n_e   = 14'sd1;
                    end else begin
                        n_stk = r_stk | r_m[0];
                        n_m   = {1'b0, r_m[63:1]};
                        n_e   = r_e + 14'sd1;
                    end
                end else begin
                    n_fst = F_ROUND;
                end
            end
            F_ROUND: begin
                if (rd_e >= 14'sd2047) begin
                    n_res = {r_s, 11'h7FF, 52'd0};
                end else begin
                    n_res = {r_s, rd_exp, rd_m[51:0]};
                end
                n_fst = F_DONE;
            end
            F_DONE: begin
                n_fst = F_IDLE;
            end
            default: begin
                n_fst = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fst <= F_IDLE;
        end else begin
            r_fst <= n_fst;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_sa  <= n_sa;
        r_sb  <= n_sb;
        r_s   <= n_s;
        r_ea  <= n_ea;
        r_eb  <= n_eb;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_m   <= n_m;
        r_e   <= n_e;
        r_stk <= n_stk;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_res <= n_res;
    end

    assign o_done = (r_fst == F_DONE);
    assign o_res  = r_res;

endmodule

// ===== hdl/blms_datapath.sv =====
`timescale 1ns / 1ps
// operand registers, running state, threshold and output register around the shared fpu
// depends on blms_pkg and blms_fpu

module blms_datapath import blms_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_s_tuser,
    input  logic             i_s_tlast,
    input  logic             i_cfg_we,
    input  logic [63:0]      i_cfg_wdata,
    output logic [OUT_W-1:0] o_m_tdata,
    output logic             o_m_tlast
);

    logic [63:0] r_xl, r_xh, r_pr, r_sxx, r_sx1, r_s11, r_cdiv, r_ediv;
    logic [63:0] r_ps, r_max, r_thr, r_vx, r_va, r_vb, r_t0, r_t1, r_th, r_n, r_tm;
    logic        r_first, r_last;
    logic [OUT_W-1:0] r_odata;
    logic        r_olast;

    logic        f_done;
    logic [63:0] f_res, op_a, op_b;

    function automatic logic [63:0] pick(input t_reg s,
        input logic [63:0] xl, xh, pr, sxx, sx1, s11, cdiv, ediv,
        input logic [63:0] ps, mx, vx, va, vb, t0, t1, th, n, tm);
        logic [63:0] v;
        case (s)
            R_XL:    v = xl;
            R_XH:    v = xh;
            R_PR:    v = pr;
            R_SXX:   v = sxx;
            R_SX1:   v = sx1;
            R_S11:   v = s11;
            R_CDIV:  v = cdiv;
            R_EDIV:  v = ediv;
            R_PS:    v = ps;
            R_MAX:   v = mx;
            R_VX:    v = vx;
            R_VA:    v = va;
            R_VB:    v = vb;
            R_T0:    v = t0;
            R_T1:    v = t1;
            R_TH:    v = th;
            R_N:     v = n;
            R_TM:    v = tm;
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    assign op_a = pick(i_cmd.uop.a, r_xl, r_xh, r_pr, r_sxx, r_sx1, r_s11, r_cdiv, r_ediv,
                       r_ps, r_max, r_vx, r_va, r_vb, r_t0, r_t1, r_th, r_n, r_tm);
    assign op_b = pick(i_cmd.uop.b, r_xl, r_xh, r_pr, r_sxx, r_sx1, r_s11, r_cdiv, r_ediv,
                       r_ps, r_max, r_vx, r_va, r_vb, r_t0, r_t1, r_th, r_n, r_tm);

    blms_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_op    (i_cmd.uop.op),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (f_done),
        .o_res   (f_res)
    );

    function automatic logic wr_to(input t_cmd c, input t_reg r);
        return c.wr && (c.uop.d == r);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps  <= 64'd0;
            r_max <= 64'd0;
            r_thr <= 64'd0;
        end else begin
            if (i_cfg_we)
                r_thr <= i_cfg_wdata;
            if (wr_to(i_cmd, R_PS))
                r_ps <= f_res;
            if (wr_to(i_cmd, R_MAX)) begin
                r_max <= f_res;
            end else if (i_cmd.upd_max && fp_gt(r_tm, r_max)) begin
                r_max <= r_tm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xl    <= i_s_tdata[63:0];
            r_xh    <= i_s_tdata[127:64];
            r_pr    <= i_s_tdata[191:128];
            r_sxx   <= i_s_tdata[255:192];
            r_sx1   <= i_s_tdata[319:256];
            r_s11   <= i_s_tdata[383:320];
            r_cdiv  <= i_s_tdata[447:384];
            r_ediv  <= i_s_tdata[511:448];
            r_first <= i_s_tuser;
            r_last  <= i_s_tlast;
        end
        if (wr_to(i_cmd, R_VX)) r_vx <= f_res;
        if (wr_to(i_cmd, R_VA)) r_va <= f_res;
        if (wr_to(i_cmd, R_VB)) r_vb <= f_res;
        if (wr_to(i_cmd, R_T0)) r_t0 <= f_res;
        if (wr_to(i_cmd, R_T1)) r_t1 <= f_res;
        if (wr_to(i_cmd, R_TH)) r_th <= f_res;
        if (wr_to(i_cmd, R_N))  r_n  <= f_res;
        if (wr_to(i_cmd, R_TM)) r_tm <= f_res;
        if (i_cmd.out_load) begin
            r_odata <= {7'd0, fp_gt(r_max, r_thr), r_max};
            r_olast <= r_last;
        end
    end

    assign o_sts.fdone    = f_done;
    assign o_sts.interior = fp_gt(r_th, r_xl) && fp_gt(r_xh, r_th);
    assign o_sts.first    = r_first;
    assign o_m_tdata      = r_odata;
    assign o_m_tlast      = r_olast;

endmodule

// ===== hdl/blms_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer: steps through the operation list, handles the breakpoint branch and output
// depends on blms_pkg

module blms_ctrl import blms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_cstate    r_cst, n_cst;
    logic [4:0] r_step, n_step;
    logic       r_mvalid, n_mvalid;

    always_comb begin
        n_cst       = r_cst;
        n_step      = r_step;
        o_cmd       = '0;
        o_cmd.uop   = blms_prog(r_step);
        case (r_cst)
            C_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_cst      = C_START;
                end
            end
            C_START: begin
                n_step = i_sts.first ? STEP_FIRST : STEP_LATER;
                n_cst  = C_ISSUE;
            end
            C_ISSUE: begin
                o_cmd.start = 1'b1;
                n_cst       = C_WAIT;
            end
            C_WAIT: begin
                if (i_sts.fdone) begin
                    o_cmd.wr = 1'b1;
                    case (o_cmd.uop.seq)
                        SQ_NEXT: begin
                            n_step = r_step + 5'd1;
                            n_cst  = C_ISSUE;
                        end
                        SQ_BRANCH: n_cst = C_BR;
                        SQ_TERM:   n_cst = C_MAX;
                        SQ_FIRST:  n_cst = C_OUT;
                        default:   n_cst = C_OUT;
                    endcase
                end
            end
            C_BR: begin
                // theta is already in its register for the interior test
                n_step = i_sts.interior ? STEP_INT : STEP_EXT;
                n_cst  = C_ISSUE;
            end
            C_MAX: begin
                o_cmd.upd_max = 1'b1;
                n_cst         = C_OUT;
            end
            C_OUT: begin
                if (!r_mvalid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_cst          = C_IDLE;
                end
            end
            default: n_cst = C_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load)
            n_mvalid = 1'b1;
        else if (i_m_tready)
            n_mvalid = 1'b0;
        else
            n_mvalid = r_mvalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cst    <= C_IDLE;
            r_step   <= STEP_FIRST;
            r_mvalid <= 1'b0;
        end else begin
            r_cst    <= n_cst;
            r_step   <= n_step;
            r_mvalid <= n_mvalid;
        end
    end

    assign o_s_tready = (r_cst == C_IDLE);
    assign o_m_tvalid = r_mvalid;

endmodule

// ===== hdl/broken_line_max_statistic.sv =====
`timescale 1ns / 1ps
// Running maximum of a squared broken-line statistic over segment beats.
// Slave stream: one beat per segment, tuser = first flag, tlast = last flag,
//   tdata = eight doubles. Master stream: one beat per segment, tlast = last flag,
//   tdata = running maximum and the over-threshold flag.
// Configuration: i_cfg_we writes the 64-bit threshold; the user must write it
// only while idle, since the block itself does not enforce this.
// Each beat runs as a sequence of double precision operations on one shared
// floating-point unit; a result is renormalized one bit shift at a time, and
// subnormal multiply and divide operands and subnormal results add further shift
// steps. A later beat runs more operations than a first beat. The 64-step divider dominates.
// A new beat is taken once the previous result is placed in the output
// register; that register holds while the master side stalls, and the next
// result waits until it has been taken.
// Reset clears partial sum, maximum and threshold to zero and empties the output.
// Depends on blms_pkg, blms_ctrl, blms_datapath, blms_fpu.

module broken_line_max_statistic import blms_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // x_low, x_high, projection, sum_xx, sum_x1, sum_11, interior_divisor, end_divisor
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    // first
    input  logic             i_s_axis_tuser,
    input  logic             i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // running_max [63:0], exceeds [64], zero pad
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    input  logic             i_cfg_we,
    input  logic [63:0]      i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    blms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    blms_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_s_tlast   (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast)
    );

    // one beat at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a beat is in progress");

    // a nan maximum never compares above the threshold
    a_nan_not_exceeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[64]) |->
        !((o_m_axis_tdata[62:52] == 11'h7FF) && (o_m_axis_tdata[51:0] != 52'd0)))
        else $error("exceeds flag set on a nan maximum");

    // the fpu is only started while a beat is in progress and the input is not ready
    a_start_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |-> !o_s_axis_tready)
        else $error("fpu started while idle");

    // output register empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for broken_line_max_statistic: segment runs in, running maximum out
// depends on blms_pkg and the block rtl; double arithmetic is predicted with real values

module tb;
    import blms_pkg::*;

    localparam logic [63:0] NAN_DEFAULT = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] POS_INF     = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF     = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] MAX_FINITE  = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          SETTLE      = 400;

    typedef struct {
        logic        first;
        logic        last;
        logic [63:0] x_low;
        logic [63:0] x_high;
        logic [63:0] proj;
        logic [63:0] sum_xx;
        logic [63:0] sum_x1;
        logic [63:0] sum_11;
        logic [63:0] int_div;
        logic [63:0] end_div;
    } seg_t;

    typedef struct {
        logic [63:0] max_bits;
        logic        over;
        logic        last;
    } stat_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;
    logic             i_s_axis_tuser;
    logic             i_s_axis_tlast;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             o_m_axis_tlast;
    logic             i_cfg_we;
    logic [63:0]      i_cfg_wdata;

    // predictor state
    real         run_sum;
    real         run_max;
    logic [63:0] thr_bits;

    stat_t       stat_q[$];
    int          errors;
    bit          long_hold;
    bit          quiet_send;
    bit          quiet_recv;

    broken_line_max_statistic dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic real quotient(input real n, input real d);
        logic [63:0] nb;
        logic [63:0] db;
        nb = $realtobits(n);
        db = $realtobits(d);
        if (d == 0.0) begin
            if (n != n || n == 0.0) begin
                return $bitstoreal(NAN_DEFAULT);
            end
            return $bitstoreal(POS_INF | ({1'b1, 63'd0} & (nb ^ db)));
        end
        return n / d;
    endfunction

    function automatic stat_t segment_stat(input seg_t s);
        real   xl;
        real   xh;
        real   v1;
        real   vx;
        real   va;
        real   vb;
        real   theta;
        real   term;
        stat_t r;
        xl = $bitstoreal(s.x_low);
        xh = $bitstoreal(s.x_high);
        v1 = $bitstoreal(s.proj);
        if (s.first) begin
            run_sum = (xh - xl) * v1;
            run_max = quotient(run_sum * run_sum, $bitstoreal(s.end_div));
        end else begin
            vx      = run_sum + v1 * xh;
            run_sum = vx - v1 * xl;
            va      = vx * $bitstoreal(s.sum_x1) - v1 * $bitstoreal(s.sum_xx);
            vb      = vx * $bitstoreal(s.sum_11) - v1 * $bitstoreal(s.sum_x1);
            theta   = quotient(va, vb);
            if (xl < theta && theta < xh) begin
                term = quotient(vx * vb - v1 * va, $bitstoreal(s.int_div));
            end else begin
                term = quotient(run_sum * run_sum, $bitstoreal(s.end_div));
            end
            if (term > run_max) begin
                run_max = term;
            end
        end
        r.max_bits = $realtobits(run_max);
        r.over     = run_max > $bitstoreal(thr_bits);
        r.last     = s.last;
        return r;
    endfunction

    task automatic send_segment(input seg_t s);
        int gap;
        gap = quiet_send ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = s.first;
        i_s_axis_tlast  = s.last;
        i_s_axis_tdata  = {s.end_div, s.int_div, s.sum_11, s.sum_x1, s.sum_xx,
                           s.sum_xx == s.sum_xx ? s.proj : s.proj, s.x_high, s.x_low};
        do @(posedge i_clk); while (!o_s_axis_tready);
        stat_q.push_back(segment_stat(s));
    endtask

    task automatic idle_and_settle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait (stat_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        thr_bits = value;
    endtask

    function automatic real pick_real();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 0.0;
        if (sel < 5) return real'($urandom_range(0, 40)) - 20.0;
        return (real'($urandom_range(0, 4000)) - 2000.0) / 64.0;
    endfunction

    function automatic logic [63:0] raw_bits();
        return {$urandom(), $urandom()};
    endfunction

    function automatic seg_t make_segment(input logic first, input logic last, input bit noisy);
        seg_t s;
        real  lo;
        s.first = first;
        s.last  = last;
        if (noisy) begin
            s.x_low   = raw_bits();
            s.x_high  = raw_bits();
            s.proj    = raw_bits();
            s.sum_xx  = raw_bits();
            s.sum_x1  = raw_bits();
            s.sum_11  = raw_bits();
            s.int_div = raw_bits();
            s.end_div = raw_bits();
        end else begin
            lo        = real'($urandom_range(0, 50)) / 4.0;
            s.x_low   = $realtobits(lo);
            s.x_high  = $realtobits(lo + real'($urandom_range(1, 40)) / 8.0);
            s.proj    = $realtobits(pick_real());
            s.sum_xx  = $realtobits(pick_real());
            s.sum_x1  = $realtobits(pick_real());
            s.sum_11  = $realtobits(pick_real());
            // zero divisors now and then
            s.int_div = $realtobits($urandom_range(0, 15) == 0 ? 0.0
                                    : real'($urandom_range(1, 300)) / 8.0);
            s.end_div = $realtobits($urandom_range(0, 15) == 0 ? 0.0
                                    : real'($urandom_range(1, 300)) / 8.0);
        end
        return s;
    endfunction

    function automatic seg_t plain_segment(input logic first, input logic last,
                                           input real xl, input real xh, input real v1,
                                           input real sxx, input real sx1, input real s11,
                                           input real cdiv, input real ediv);
        seg_t s;
        s.first   = first;
        s.last    = last;
        s.x_low   = $realtobits(xl);
        s.x_high  = $realtobits(xh);
        s.proj    = $realtobits(v1);
        s.sum_xx  = $realtobits(sxx);
        s.sum_x1  = $realtobits(sx1);
        s.sum_11  = $realtobits(s11);
        s.int_div = $realtobits(cdiv);
        s.end_div = $realtobits(ediv);
        return s;
    endfunction

    // later segments straight after reset work on the zero state
    task automatic test_without_first();
        send_segment(plain_segment(0, 0, 0.0, 2.0, 1.5, 1.0, 2.0, 3.0, 2.0, 4.0));
        send_segment(plain_segment(0, 1, 1.0, 3.0, -2.0, 0.5, 1.0, 1.0, 1.0, 1.0));
    endtask

    task automatic test_directed_runs();
        seg_t s;
        // end segment alone, first and last together
        send_segment(plain_segment(1, 1, 0.0, 3.0, 2.0, 0.0, 0.0, 0.0, 0.0, 2.0));
        // run with an interior breakpoint, then one at the end point
        send_segment(plain_segment(1, 0, 0.0, 1.0, 0.0, 0.0, 0.0, 0.0, 1.0, 1.0));
        send_segment(plain_segment(0, 0, 0.0, 2.0, 1.0, 0.0, 1.0, 2.0, 0.5, 1.0));
        send_segment(plain_segment(0, 1, 5.0, 6.0, 3.0, 1.0, 1.0, 1.0, 1.0, 0.25));
        // zero divisors, positive and zero numerators
        send_segment(plain_segment(1, 0, 0.0, 1.0, 2.0, 0.0, 0.0, 0.0, 1.0, 0.0));
        send_segment(plain_segment(1, 0, 0.0, 1.0, 0.0, 0.0, 0.0, 0.0, 1.0, 0.0));
        send_segment(plain_segment(0, 0, 0.0, 2.0, 1.0, 0.0, 1.0, 2.0, 0.0, 1.0));
        send_segment(plain_segment(0, 1, 0.0, 2.0, 1.0, 0.0, 1.0, 2.0, -0.0, -0.0));
        // extreme patterns
        s = plain_segment(1, 0, 0.0, 0.0, 0.0, 0.0, 0.0, 0.0, 0.0, 0.0);
        s.x_high = MAX_FINITE;
        s.proj   = MAX_FINITE;
        s.end_div = 64'd1;
        send_segment(s);
        s.first = 0;
        s.x_low = NEG_INF;
        s.x_high = POS_INF;
        send_segment(s);
        s.x_low = ALL_ONES; s.x_high = ALL_ONES; s.proj = ALL_ONES; s.sum_xx = ALL_ONES;
        s.sum_x1 = ALL_ONES; s.sum_11 = ALL_ONES; s.int_div = ALL_ONES; s.end_div = ALL_ONES;
        s.first = 1;
        send_segment(s);
        // nan maximum stays in place
        s.first = 0; s.last = 1;
        s.x_low = '0; s.x_high = 64'h3FF0_0000_0000_0000; s.proj = s.x_high;
        s.sum_xx = '0; s.sum_x1 = '0; s.sum_11 = '0; s.int_div = s.x_high; s.end_div = '0;
        send_segment(s);
        // subnormal operands
        send_segment(plain_segment(1, 0, 0.0, 1.0, $bitstoreal(64'd3), 0.0, 0.0, 0.0,
                                   1.0, $bitstoreal(64'd1)));
        send_segment(plain_segment(0, 1, 0.0, 1.0, $bitstoreal(64'h000F_FFFF_FFFF_FFFF),
                                   1.0, 1.0, 1.0, 1.0, 3.0));
        idle_and_settle();
    endtask

    task automatic test_random_runs(input int count);
        int   len;
        int   sent;
        bit   noisy;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 12);
            if ($urandom_range(0, 7) == 0) begin
                quiet_send = ~quiet_send;
                quiet_recv = ~quiet_recv;
            end
            for (int k = 0; k < len; k++) begin
                noisy = $urandom_range(0, 9) == 0;
                if ($urandom_range(0, 19) == 0) begin
                    // broken run: flags at random
                    send_segment(make_segment($urandom_range(0, 1), $urandom_range(0, 1), noisy));
                end else begin
                    send_segment(make_segment(k == 0, k == len - 1, noisy));
                end
                sent++;
            end
        end
        quiet_send = 0;
        quiet_recv = 0;
        idle_and_settle();
    endtask

    // output register and engine fill up while the sender keeps offering
    task automatic test_output_stall();
        long_hold = 1;
        test_random_runs(30);
    endtask

    task automatic test_thresholds();
        logic [63:0] levels [6];
        levels = '{64'd0, MAX_FINITE, POS_INF, ALL_ONES, 64'h4059_0000_0000_0000,
                   64'hC059_0000_0000_0000};
        foreach (levels[i]) begin
            write_threshold(levels[i]);
            test_random_runs(270);
        end
        write_threshold(raw_bits());
        test_random_runs(120);
        write_threshold(64'h4024_0000_0000_0000);
        test_output_stall();
    endtask

    // receiver: random stalls per beat, one long hold when asked
    initial begin
        int n;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                n = 3000;
                long_hold = 0;
            end else begin
                n = quiet_recv ? 0 : $urandom_range(0, 14);
            end
            @(negedge i_clk);
            if (n > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        stat_t e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (stat_q.size() == 0) begin
                errors++;
                $display("%t unexpected beat: max %h", $realtime, o_m_axis_tdata[63:0]);
            end else begin
                e = stat_q.pop_front();
                if (o_m_axis_tdata[63:0] !== e.max_bits) begin
                    errors++;
                    $display("%t running_max expected %h actual %h", $realtime,
                             e.max_bits, o_m_axis_tdata[63:0]);
                end
                if (o_m_axis_tdata[64] !== e.over) begin
                    errors++;
                    $display("%t exceeds expected %b actual %b", $realtime,
                             e.over, o_m_axis_tdata[64]);
                end
                if (o_m_axis_tlast !== e.last) begin
                    errors++;
                    $display("%t final_res expected %b actual %b", $realtime,
                             e.last, o_m_axis_tlast);
                end
            end
        end
    end

    initial begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        errors          = 0;
        long_hold       = 0;
        quiet_send      = 0;
        quiet_recv      = 0;
        run_sum         = 0.0;
        run_max         = 0.0;
        thr_bits        = '0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_s_axis_tlast  = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_without_first();
        test_directed_runs();
        test_thresholds();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== broken_line_max_statistic.f =====
hdl/blms_pkg.sv
hdl/blms_fpu.sv
hdl/blms_datapath.sv
hdl/blms_ctrl.sv
hdl/broken_line_max_statistic.sv
dv/tb.sv
